// File: sv/dhcprp_pkg.sv
// Shared types and constants of the DHCP reply parser.
// It has no dependencies. The parse core and the top level use it.
`timescale 1ns / 1ps
`default_nettype none

package dhcprp_pkg;

    localparam int MAX_MESSAGE_BYTES = 1024;
    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] POS_XID_FIRST = POS_W'(4);
    localparam logic [POS_W-1:0] POS_XID_LAST  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_YIP_FIRST = POS_W'(16);
    localparam logic [POS_W-1:0] POS_YIP_LAST  = POS_W'(19);
    localparam logic [POS_W-1:0] POS_OPT_START = POS_W'(240);

    localparam logic [7:0] TAG_MSG_TYPE = 8'd53;
    localparam logic [7:0] TAG_SUBNET   = 8'd1;
    localparam logic [7:0] TAG_ROUTER   = 8'd3;

    localparam logic [7:0] MSG_OFFER = 8'h02;
    localparam logic [7:0] MSG_ACK   = 8'h05;

    typedef enum logic [1:0] {
        KIND_IGNORE = 2'd0,
        KIND_OFFER  = 2'd1,
        KIND_ACK    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [31:0] xid;
        logic [31:0] yip;
        logic [31:0] mask;
        logic [31:0] router;
    } t_parse_res;

endpackage

`default_nettype wire

// File: sv/dhcprp_parse.sv
// Per-byte parse state of the DHCP reply parser: header capture and option walk.
// It depends on dhcprp_pkg and is instantiated by dhcp_reply_parser.
`timescale 1ns / 1ps
`default_nettype none

module dhcprp_parse (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_advance,
    input  wire  [7:0]              i_byte,
    input  wire                     i_last,
    output dhcprp_pkg::t_parse_res  o_res
);

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_SKIP = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        TGT_NONE   = 2'd0,
        TGT_TYPE   = 2'd1,
        TGT_MASK   = 2'd2,
        TGT_ROUTER = 2'd3
    } t_target;

    logic [dhcprp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [31:0] r_xid, n_xid;
    logic [31:0] r_yip, n_yip;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_router, n_router;
    logic [7:0]  r_msg_type, n_msg_type;
    logic [7:0]  r_skip, n_skip;
    logic [2:0]  r_cap_cnt, n_cap_cnt;
    t_phase      r_phase, n_phase;
    t_target     r_target, n_target;

    function automatic logic [2:0] cap_size(input t_target tgt);
        unique case (tgt)
            TGT_TYPE:              cap_size = 3'd1;
            TGT_MASK, TGT_ROUTER:  cap_size = 3'd4;
            default:               cap_size = 3'd0;
        endcase
    endfunction

    always_comb begin
        n_pos      = r_pos;
        n_xid      = r_xid;
        n_yip      = r_yip;
        n_mask     = r_mask;
        n_router   = r_router;
        n_msg_type = r_msg_type;
        n_skip     = r_skip;
        n_cap_cnt  = r_cap_cnt;
        n_phase    = r_phase;
        n_target   = r_target;

        if (r_pos < dhcprp_pkg::POS_LIMIT) begin
            if (r_pos >= dhcprp_pkg::POS_XID_FIRST && r_pos <= dhcprp_pkg::POS_XID_LAST) begin
                n_xid = {r_xid[23:0], i_byte};
            end
            if (r_pos >= dhcprp_pkg::POS_YIP_FIRST && r_pos <= dhcprp_pkg::POS_YIP_LAST) begin
                n_yip = {r_yip[23:0], i_byte};
            end

            if (r_pos >= dhcprp_pkg::POS_OPT_START) begin
                // The first count step skips the length byte of the option.
                if (r_cap_cnt != 3'd0) begin
                    if (r_cap_cnt <= cap_size(r_target)) begin
                        case (r_target)
                            TGT_TYPE:   n_msg_type = i_byte;
                            TGT_MASK:   n_mask     = {r_mask[23:0], i_byte};
                            TGT_ROUTER: n_router   = {r_router[23:0], i_byte};
                            default:    ;
                        endcase
                    end
                    n_cap_cnt = r_cap_cnt - 3'd1;
                    if (n_cap_cnt == 3'd0) begin
                        n_target = TGT_NONE;
                    end
                end

                unique case (r_phase)
                    PH_TAG: begin
                        if (!i_last) begin
                            if (i_byte == dhcprp_pkg::TAG_MSG_TYPE) begin
                                n_target  = TGT_TYPE;
                                n_cap_cnt = cap_size(TGT_TYPE) + 3'd1;
                            end else if (i_byte == dhcprp_pkg::TAG_SUBNET) begin
                                n_target  = TGT_MASK;
                                n_cap_cnt = cap_size(TGT_MASK) + 3'd1;
                            end else if (i_byte == dhcprp_pkg::TAG_ROUTER) begin
                                n_target  = TGT_ROUTER;
                                n_cap_cnt = cap_size(TGT_ROUTER) + 3'd1;
                            end
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_skip  = i_byte;
                        n_phase = (i_byte == 8'd0) ? PH_TAG : PH_SKIP;
                    end
                    PH_SKIP: begin
                        if (r_skip != 8'd0) begin
                            n_skip = r_skip - 8'd1;
                        end
                        if (n_skip == 8'd0) begin
                            n_phase = PH_TAG;
                        end
                    end
                    default: begin
                        n_phase = PH_TAG;
                    end
                endcase
            end
            n_pos = r_pos + dhcprp_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_pos      <= '0;
            r_xid      <= '0;
            r_yip      <= '0;
            r_mask     <= '0;
            r_router   <= '0;
            r_msg_type <= '0;
            r_skip     <= '0;
            r_cap_cnt  <= '0;
            r_phase    <= PH_TAG;
            r_target   <= TGT_NONE;
        end else if (i_advance) begin
            r_pos      <= n_pos;
            r_xid      <= n_xid;
            r_yip      <= n_yip;
            r_mask     <= n_mask;
            r_router   <= n_router;
            r_msg_type <= n_msg_type;
            r_skip     <= n_skip;
            r_cap_cnt  <= n_cap_cnt;
            r_phase    <= n_phase;
            r_target   <= n_target;
        end
    end

    assign o_res.msg_type = n_msg_type;
    assign o_res.xid      = n_xid;
    assign o_res.yip      = n_yip;
    assign o_res.mask     = n_mask;
    assign o_res.router   = n_router;

endmodule

`default_nettype wire

// File: sv/dhcp_reply_parser.sv
// DHCP reply parser: one message byte per cycle, one result on the last byte.
// The last byte waits in the input register; its result is registered in the output
// register when that byte advances. Throughput: one byte per cycle;
// input stalls only while a last byte waits for a full result register.
// Reset is synchronous, active low; it clears the parse state and sets expected_xid to zero.
// It depends on dhcprp_pkg and dhcprp_parse.
`timescale 1ns / 1ps
`default_nettype none

module dhcp_reply_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [31:0]  i_cfg_data,     // expected_xid
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // data_byte
    input  wire          s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // From bit 0: reply_kind[1:0], xid_match[2], offered_ip[34:3],
    // subnet_mask[66:35], router_addr[98:67], zero fill[103:99].
    output logic [103:0] m_axis_tdata
);

    logic [31:0] r_exp_xid;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        advance;

    dhcprp_pkg::t_parse_res res;
    dhcprp_pkg::t_kind      kind;
    logic                   match;

    logic                   r_out_valid;
    dhcprp_pkg::t_kind      r_out_kind;
    logic                   r_out_match;
    logic [31:0]            r_out_yip;
    logic [31:0]            r_out_mask;
    logic [31:0]            r_out_router;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_xid <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_exp_xid <= i_cfg_data;
        end
    end

    assign advance = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    dhcprp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_res     (res)
    );

    always_comb begin
        match = (res.xid == r_exp_xid);
        kind  = dhcprp_pkg::KIND_IGNORE;
        if (match) begin
            if (res.msg_type == dhcprp_pkg::MSG_OFFER) begin
                kind = dhcprp_pkg::KIND_OFFER;
            end else if (res.msg_type == dhcprp_pkg::MSG_ACK) begin
                kind = dhcprp_pkg::KIND_ACK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_kind   <= kind;
            r_out_match  <= match;
            r_out_yip    <= res.yip;
            r_out_mask   <= res.mask;
            r_out_router <= res.router;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_router, r_out_mask, r_out_yip, r_out_match, r_out_kind};

    a_kind_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_kind == dhcprp_pkg::KIND_IGNORE || r_out_match))
        else $error("reply kind set without identifier match");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_valid)
        else $error("accepted byte not held in input register");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_out_valid)
        else $error("last byte did not produce a result");

    a_stall_only_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |-> r_in_last && r_out_valid)
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire
